>>> hdl/stable_sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// stable sorted priority queue assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define SSPQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sspq check failed in the same cycle");
`define SSPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sspq check failed in the next cycle");
`else
`define SSPQ_ASSERT_SAME(label, ante, cons)
`define SSPQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hdl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// shared codes of the stable sorted priority queue
// ----------------------------------------------------------------------------
package sspq_pkg;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } cell_op_t;

endpackage

>>> hdl/sspq_cell.sv
// ----------------------------------------------------------------------------
// sspq_cell
// one slot of the sorted chain: keeps, takes the new entry, or takes a neighbor
// ----------------------------------------------------------------------------
module sspq_cell
    import sspq_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int PW         = 15
)
(
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic                  occupied,
    input  logic [DATA_WIDTH-1:0] new_data,
    input  logic [PW-1:0]         new_prio,
    input  logic                  left_ge,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [PW-1:0]         left_prio,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [PW-1:0]         right_prio,
    output logic                  ge,
    output logic [DATA_WIDTH-1:0] data,
    output logic [PW-1:0]         prio
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [PW-1:0]         prio_reg;
    logic [PW-1:0]         prio_next;

    assign ge   = occupied && (prio_reg >= new_prio);
    assign data = data_reg;
    assign prio = prio_reg;

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        case (op)
            OP_INSERT:
            begin
                if (!ge)
                begin
                    if (left_ge)
                    begin
                        data_next = new_data;
                        prio_next = new_prio;
                    end
                    else
                    begin
                        data_next = left_data;
                        prio_next = left_prio;
                    end
                end
            end
            OP_SHIFT:
            begin
                data_next = right_data;
                prio_next = right_prio;
            end
            default:
            begin
                data_next = data_reg;
                prio_next = prio_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

endmodule

>>> hdl/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue held as a chain of DEPTH slots in sorted order,
// highest priority first and arrival order among equal priorities. One item
// is taken per cycle while the result register is free or being emptied;
// the result is shown in the cycle after the item is accepted. Each add is
// settled in the cycle it is taken: every slot compares its priority with the
// new one and keeps its entry, takes the new entry, or takes its left
// neighbor's, so the slot compare plus neighbor select sets the clock path.
// A remove shifts every slot one place toward the front. An add to a full
// queue is discarded and flagged as dropped.
// ----------------------------------------------------------------------------
`include "stable_sorted_priority_queue_defines.svh"

module stable_sorted_priority_queue
    import sspq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int PRIO_WIDTH = 16,
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int PW        = PRIO_WIDTH - 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [DATA_WIDTH-1:0]        item_data,
    input  logic signed [PRIO_WIDTH-1:0] item_priority,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [DATA_WIDTH-1:0]        front_data,
    output logic [PW-1:0]                front_priority,
    output logic [DATA_WIDTH-1:0]        back_data,
    output logic [CW-1:0]                entry_count,
    output logic                         is_empty,
    output logic                         dropped
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  dropped_reg;
    logic                  dropped_next;
    logic [DATA_WIDTH-1:0] back_data_reg;
    logic [DATA_WIDTH-1:0] back_data_next;
    logic [PW-1:0]         back_prio_reg;
    logic [PW-1:0]         back_prio_next;

    logic                  fire;
    logic                  full;
    logic                  nonempty;
    logic                  do_add;
    logic                  do_rem;
    logic                  do_drop;
    logic                  tail_insert;
    logic [PW-1:0]         new_prio;
    cell_op_t              op;

    logic                  cell_ge   [DEPTH];
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [PW-1:0]         cell_prio [DEPTH];

    // priorities below one are stored as one
    assign new_prio = (item_priority < PRIO_WIDTH'(signed'(1))) ? PW'(1)
                                                                 : item_priority[PW-1:0];

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign full     = (count_reg == FULL_COUNT);
    assign nonempty = (count_reg != '0);
    assign do_add   = fire && (mode == MODE_ADD) && !full;
    assign do_drop  = fire && (mode == MODE_ADD) && full;
    assign do_rem   = fire && (mode == MODE_REMOVE) && nonempty;

    // the tail holds the lowest priority, so it alone decides a tail insert
    assign tail_insert = !nonempty || (back_prio_reg >= new_prio);

    always_comb
    begin
        if (do_add)
        begin
            op = OP_INSERT;
        end
        else if (do_rem)
        begin
            op = OP_SHIFT;
        end
        else
        begin
            op = OP_HOLD;
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(i);
            logic                  l_ge;
            logic [DATA_WIDTH-1:0] l_data;
            logic [PW-1:0]         l_prio;
            logic [DATA_WIDTH-1:0] r_data;
            logic [PW-1:0]         r_prio;

            if (i == 0)
            begin : g_first
                assign l_ge   = 1'b1;
                assign l_data = item_data;
                assign l_prio = new_prio;
            end
            else
            begin : g_inner_left
                assign l_ge   = cell_ge[i-1];
                assign l_data = cell_data[i-1];
                assign l_prio = cell_prio[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign r_data = cell_data[i];
                assign r_prio = cell_prio[i];
            end
            else
            begin : g_inner_right
                assign r_data = cell_data[i+1];
                assign r_prio = cell_prio[i+1];
            end

            sspq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .PW         (PW)
            ) u_cell (
                .clk        (clk),
                .op         (op),
                .occupied   (IDX < count_reg),
                .new_data   (item_data),
                .new_prio   (new_prio),
                .left_ge    (l_ge),
                .left_data  (l_data),
                .left_prio  (l_prio),
                .right_data (r_data),
                .right_prio (r_prio),
                .ge         (cell_ge[i]),
                .data       (cell_data[i]),
                .prio       (cell_prio[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        back_data_next = back_data_reg;
        back_prio_next = back_prio_reg;
        if (do_add)
        begin
            count_next = count_reg + ONE_COUNT;
            if (tail_insert)
            begin
                back_data_next = item_data;
                back_prio_next = new_prio;
            end
        end
        else if (do_rem)
        begin
            count_next = count_reg - ONE_COUNT;
        end
        dropped_next   = fire ? do_drop : dropped_reg;
        out_valid_next = fire ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            dropped_reg   <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        back_data_reg <= back_data_next;
        back_prio_reg <= back_prio_next;
    end

    assign out_valid      = out_valid_reg;
    assign front_data     = nonempty ? cell_data[0] : '0;
    assign front_priority = nonempty ? cell_prio[0] : '0;
    assign back_data      = nonempty ? back_data_reg : '0;
    assign entry_count    = count_reg;
    assign is_empty       = !nonempty;
    assign dropped        = dropped_reg;

    `SSPQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= FULL_COUNT)
    `SSPQ_ASSERT_NEXT(a_full_add_dropped, do_drop, dropped_reg && (count_reg == $past(count_reg)))
    `SSPQ_ASSERT_NEXT(a_remove_count, do_rem, count_reg == ($past(count_reg) - ONE_COUNT))
    `SSPQ_ASSERT_SAME(a_front_not_below_back, nonempty, cell_prio[0] >= back_prio_reg)

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stable sorted priority queue. A shadow copy of
// the sorted slots predicts the view reported after every accepted item.
// A short directed table covers empty, full, tie and clamped-priority cases,
// then random add, remove and query traffic runs in draining, balanced and
// filling phases, with random stalls on both handshakes for the first two thirds of the items.
// ----------------------------------------------------------------------------
module tb
    import sspq_pkg::*;
();

    localparam int DEPTH = 16;
    localparam int NUM_ITEMS = 1650;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        data;
        logic signed [15:0] prio;
    } item_t;

    typedef struct packed {
        logic [31:0] front_data;
        logic [14:0] front_prio;
        logic [31:0] back_data;
        logic [4:0]  count;
        logic        empty;
        logic        drop;
    } queue_view_t;

    typedef struct packed {
        item_t       item;
        logic        typed;
        queue_view_t view;
    } dir_row_t;

    localparam queue_view_t EMPTY_VIEW = '{32'd0, 15'd0, 32'd0, 5'd0, 1'b1, 1'b0};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         mode = MODE_QUERY;
    logic [31:0]        item_data = 32'd0;
    logic signed [15:0] item_priority = 16'sd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [31:0]        front_data;
    logic [14:0]        front_priority;
    logic [31:0]        back_data;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic               dropped;

    logic [31:0]        shadow_data [DEPTH];
    logic [14:0]        shadow_prio [DEPTH];
    int                 shadow_count = 0;
    queue_view_t        awaited_views [$];
    int                 mismatches = 0;
    int                 send_idle_pct = 24;
    int                 recv_idle_pct = 73;
    int                 stall_cycles = 0;

    stable_sorted_priority_queue u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .item_data      (item_data),
        .item_priority  (item_priority),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .front_data     (front_data),
        .front_priority (front_priority),
        .back_data      (back_data),
        .entry_count    (entry_count),
        .is_empty       (is_empty),
        .dropped        (dropped)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic queue_view_t step_shadow_queue(item_t it);
        queue_view_t v;
        logic [14:0] p;
        int          pos;
        v = '0;
        if (it.mode == MODE_ADD)
        begin
            p = ($signed(it.prio) < 16'sd1) ? 15'd1 : it.prio[14:0];
            if (shadow_count >= DEPTH)
            begin
                v.drop = 1'b1;
            end
            else
            begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= p)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_data[i] = shadow_data[i-1];
                    shadow_prio[i] = shadow_prio[i-1];
                end
                shadow_data[pos] = it.data;
                shadow_prio[pos] = p;
                shadow_count++;
            end
        end
        else if (it.mode == MODE_REMOVE && shadow_count > 0)
        begin
            for (int i = 1; i < shadow_count; i++)
            begin
                shadow_data[i-1] = shadow_data[i];
                shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
        end
        if (shadow_count > 0)
        begin
            v.front_data = shadow_data[0];
            v.front_prio = shadow_prio[0];
            v.back_data  = shadow_data[shadow_count-1];
        end
        v.count = 5'(shadow_count);
        v.empty = (shadow_count == 0);
        return v;
    endfunction

    function automatic dir_row_t dir_row(logic [1:0] m, logic [31:0] d, logic [15:0] p,
                                         logic typed, queue_view_t v);
        dir_row_t r;
        r.item  = '{m, d, p};
        r.typed = typed;
        r.view  = v;
        return r;
    endfunction

    function automatic item_t random_item(int add_pct);
        item_t it;
        int    r;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            it.mode = MODE_ADD;
        else if (r < 88)
            it.mode = MODE_REMOVE;
        else if (r < 96)
            it.mode = MODE_QUERY;
        else
            it.mode = MODE_UNUSED;
        if ($urandom_range(0, 15) == 0)
            it.data = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
        else
            it.data = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: it.prio = 16'($urandom_range(1, 4));
            4, 5, 6:    it.prio = 16'($urandom);
            7:          it.prio = $urandom_range(0, 1) ? 16'h0000
                                                      : 16'($urandom_range(32768, 65535));
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       it.prio = 16'h7fff;
                    1:       it.prio = 16'h8000;
                    2:       it.prio = 16'hffff;
                    default: it.prio = 16'h0001;
                endcase
            end
            default:    it.prio = 16'($urandom_range(1, 32767));
        endcase
        return it;
    endfunction

    task automatic check_result();
        queue_view_t got;
        queue_view_t want;
        got = '{front_data, front_priority, back_data, entry_count, is_empty, dropped};
        if (awaited_views.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result: front %h/%h back %h count %0d empty %b drop %b",
                         got.front_data, got.front_prio, got.back_data, got.count,
                         got.empty, got.drop);
        end
        else
        begin
            want = awaited_views.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("mismatch expected: front %h/%h back %h count %0d empty %b drop %b",
                             want.front_data, want.front_prio, want.back_data, want.count,
                             want.empty, want.drop);
                    $display("         actual:   front %h/%h back %h count %0d empty %b drop %b",
                             got.front_data, got.front_prio, got.back_data, got.count,
                             got.empty, got.drop);
                end
            end
        end
    endtask

    // result side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result();
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        dir_row_t rows [$];
        item_t    it;
        int       add_pct;
        add_pct = 50;

        // empty queue
        rows.push_back(dir_row(MODE_QUERY, 32'h0, 16'h0, 1'b1, EMPTY_VIEW));
        rows.push_back(dir_row(MODE_REMOVE, 32'h0, 16'h0, 1'b1, EMPTY_VIEW));
        rows.push_back(dir_row(MODE_UNUSED, 32'hffff_ffff, 16'hffff, 1'b1, EMPTY_VIEW));
        // extremes, clamped priorities, ties kept in arrival order
        rows.push_back(dir_row(MODE_ADD, 32'hffff_ffff, 16'h7fff, 1'b1,
                               '{32'hffff_ffff, 15'h7fff, 32'hffff_ffff, 5'd1, 1'b0, 1'b0}));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0000, 16'h8000, 1'b1,
                               '{32'hffff_ffff, 15'h7fff, 32'h0000_0000, 5'd2, 1'b0, 1'b0}));
        rows.push_back(dir_row(MODE_ADD, 32'ha5a5_a5a5, 16'h0000, 1'b1,
                               '{32'hffff_ffff, 15'h7fff, 32'ha5a5_a5a5, 5'd3, 1'b0, 1'b0}));
        rows.push_back(dir_row(MODE_ADD, 32'h5a5a_5a5a, 16'h0001, 1'b1,
                               '{32'hffff_ffff, 15'h7fff, 32'h5a5a_5a5a, 5'd4, 1'b0, 1'b0}));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0001, 16'hffff, 1'b1,
                               '{32'hffff_ffff, 15'h7fff, 32'h0000_0001, 5'd5, 1'b0, 1'b0}));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0002, 16'h7fff, 1'b0, '0));
        rows.push_back(dir_row(MODE_REMOVE, 32'h0, 16'h0, 1'b0, '0));
        // fill to full
        rows.push_back(dir_row(MODE_ADD, 32'h1234_5678, 16'h4000, 1'b0, '0));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0010, 16'h0002, 1'b0, '0));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0011, 16'h7ffe, 1'b0, '0));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0012, 16'h0001, 1'b0, '0));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0013, 16'h8001, 1'b0, '0));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0014, 16'h1234, 1'b0, '0));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0015, 16'h0002, 1'b0, '0));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0016, 16'h7fff, 1'b0, '0));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0017, 16'h0100, 1'b0, '0));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0018, 16'h0003, 1'b0, '0));
        rows.push_back(dir_row(MODE_ADD, 32'h0000_0019, 16'h4000, 1'b0, '0));
        // add to a full queue is dropped
        rows.push_back(dir_row(MODE_ADD, 32'hdead_beef, 16'h7fff, 1'b0, '0));
        rows.push_back(dir_row(MODE_UNUSED, 32'h0, 16'h0, 1'b0, '0));
        rows.push_back(dir_row(MODE_REMOVE, 32'h0, 16'h0, 1'b0, '0));
        rows.push_back(dir_row(MODE_QUERY, 32'h0, 16'h0, 1'b0, '0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < NUM_ITEMS; n++)
        begin
            if (n < NUM_ITEMS / 3)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 73;
            end
            else if (n < 2 * NUM_ITEMS / 3)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (n < rows.size())
            begin
                it = rows[n].item;
            end
            else
            begin
                // alternate draining, balanced and filling stretches
                if ((n - rows.size()) % 40 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       add_pct = 20;
                        1:       add_pct = 50;
                        default: add_pct = 80;
                    endcase
                end
                it = random_item(add_pct);
            end

            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid      <= 1'b1;
            mode          <= it.mode;
            item_data     <= it.data;
            item_priority <= it.prio;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);

            if (n < rows.size() && rows[n].typed)
            begin
                void'(step_shadow_queue(it));
                awaited_views.push_back(rows[n].view);
            end
            else
            begin
                awaited_views.push_back(step_shadow_queue(it));
            end
        end
        in_valid <= 1'b0;

        while (awaited_views.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/sspq_pkg.sv
hdl/sspq_cell.sv
hdl/stable_sorted_priority_queue.sv
verif/tb.sv
